// ===== rtl/sstf_pkg.sv =====
package sstf_pkg;

    localparam int MAX_REQUESTS  = 32;
    localparam int CYLINDER_BITS = 16;

    localparam int IN_CYL_W = 16;
    localparam int HEAD_W   = 16;
    localparam int TOTAL_W  = 21;
    localparam int IDX_W    = $clog2(MAX_REQUESTS);
    localparam int CNT_W    = $clog2(MAX_REQUESTS + 1);
    localparam int ACC_W    = ((CYLINDER_BITS > TOTAL_W) ? CYLINDER_BITS : TOTAL_W) + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // register select, decoded from paddr[2]
    localparam logic REG_START_HEAD = 1'b0;

    typedef logic [CYLINDER_BITS-1:0] cyl_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef struct packed {
        logic found;
        cyl_t span;
        idx_t idx;
        cyl_t cyl;
    } sstf_link_t;

    typedef struct packed {
        logic wr_en;
        idx_t wr_idx;
        cyl_t wr_cyl;
        logic mark_en;
        idx_t mark_idx;
        logic clr;
        cyl_t head;
    } sstf_cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_SWEEP
    } sstf_state_t;

endpackage

// ===== rtl/sstf_seek_total_top.sv =====
// Load: one request transaction per cycle while loading.
// Schedule: each pick waits for a full sweep of the chain (the nearest-request search ripples
// one cell per cycle down the chain); a batch of k stored requests shows its result
// after k picks and one extra sweep that finds none left.
// The next batch may load while the result waits on the output register.
// Reset (aresetn low, synchronous) clears control, counts, flags; stored cylinders are kept.
module sstf_seek_total_top
    import sstf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_CYL_W-1:0]   s_cylinder,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TOTAL_W-1:0]    m_total_movement,
    output logic                  m_overflow,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [HEAD_W-1:0] start_head_reg, start_head_next;
    logic              reg_sel;
    logic              cfg_wr;

    sstf_cell_ctrl_t cell_ctrl;
    sstf_link_t      link [MAX_REQUESTS+1];

    always_comb begin
        reg_sel         = paddr[APB_ADDR_W-1];
        cfg_wr          = psel && penable && pwrite;
        start_head_next = start_head_reg;
        if (cfg_wr && (reg_sel == REG_START_HEAD)) begin
            start_head_next = pwdata[HEAD_W-1:0];
        end
        unique case (reg_sel)
            REG_START_HEAD: prdata = APB_DATA_W'(start_head_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_head_reg <= '0;
        end else begin
            start_head_reg <= start_head_next;
        end
    end

    assign link[0] = '0;

    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        sstf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .ctrl     (cell_ctrl),
            .link_in  (link[g]),
            .link_out (link[g+1])
        );
    end

    sstf_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cylinder       (s_cylinder),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_total_movement (m_total_movement),
        .m_overflow       (m_overflow),
        .start_head       (start_head_reg),
        .pick             (link[MAX_REQUESTS]),
        .cell_ctrl        (cell_ctrl)
    );

endmodule

// ===== rtl/sstf_cell.sv =====
module sstf_cell
    import sstf_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  idx_t            cell_idx,
    input  sstf_cell_ctrl_t ctrl,
    input  sstf_link_t      link_in,
    output sstf_link_t      link_out
);

    logic       occ_reg, occ_next;
    logic       served_reg, served_next;
    cyl_t       cyl_reg, cyl_next;
    sstf_link_t link_reg, link_next;

    cyl_t span;
    logic cand;
    logic better;
    logic wr_hit;
    logic mark_hit;

    always_comb begin
        span     = (cyl_reg >= ctrl.head) ? (cyl_reg - ctrl.head) : (ctrl.head - cyl_reg);
        cand     = occ_reg & ~served_reg;
        // strict compare: an earlier cell keeps a tie
        better   = cand && (!link_in.found || (span < link_in.span));
        wr_hit   = ctrl.wr_en && (ctrl.wr_idx == cell_idx);
        mark_hit = ctrl.mark_en && (ctrl.mark_idx == cell_idx);

        if (better) begin
            link_next.found = 1'b1;
            link_next.span  = span;
            link_next.idx   = cell_idx;
            link_next.cyl   = cyl_reg;
        end else begin
            link_next = link_in;
        end

        occ_next    = occ_reg;
        served_next = served_reg;
        cyl_next    = cyl_reg;
        if (ctrl.clr) begin
            occ_next    = 1'b0;
            served_next = 1'b0;
        end else if (wr_hit) begin
            occ_next    = 1'b1;
            served_next = 1'b0;
            cyl_next    = ctrl.wr_cyl;
        end else if (mark_hit) begin
            served_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= 1'b0;
            served_reg <= 1'b0;
        end else begin
            occ_reg    <= occ_next;
            served_reg <= served_next;
        end
    end

    always_ff @(posedge aclk) begin
        cyl_reg  <= cyl_next;
        link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule

// ===== rtl/sstf_ctrl.sv =====
module sstf_ctrl
    import sstf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IN_CYL_W-1:0] s_cylinder,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TOTAL_W-1:0]  m_total_movement,
    output logic                m_overflow,
    input  logic [HEAD_W-1:0]   start_head,
    input  sstf_link_t          pick,
    output sstf_cell_ctrl_t     cell_ctrl
);

    sstf_state_t state_reg, state_next;

    cnt_t               count_reg, count_next;
    cnt_t               sweep_reg, sweep_next;
    cyl_t               head_reg, head_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic               dropped_reg, dropped_next;
    logic               m_valid_reg, m_valid_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;
    logic               m_overflow_reg, m_overflow_next;

    logic             accept;
    logic             full;
    logic             sweep_done;
    logic             take_pick;
    logic             finish;
    logic [ACC_W-1:0] acc;

    always_comb begin
        full       = (count_reg == CNT_W'(MAX_REQUESTS));
        sweep_done = (state_reg == ST_SWEEP) && (sweep_reg == CNT_W'(MAX_REQUESTS));
        take_pick  = sweep_done && pick.found;
        finish     = sweep_done && !pick.found && (!m_valid_reg || m_ready);
        accept     = s_valid && (state_reg == ST_LOAD);
        acc        = ACC_W'(sum_reg) + ACC_W'(pick.span);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_last) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (finish) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready         = (state_reg == ST_LOAD);
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        head_next       = head_reg;
        sum_next        = sum_reg;
        sweep_next      = sweep_reg;
        m_valid_next    = m_valid_reg;
        m_total_next    = m_total_reg;
        m_overflow_next = m_overflow_reg;

        if (accept) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + 1'b1;
            end
            if (s_last) begin
                head_next = CYLINDER_BITS'(start_head);
                sum_next  = '0;
            end
        end

        if (state_reg == ST_LOAD) begin
            sweep_next = '0;
        end else if (take_pick) begin
            sweep_next = '0;
        end else if (!sweep_done) begin
            sweep_next = sweep_reg + 1'b1;
        end

        if (take_pick) begin
            head_next = pick.cyl;
            sum_next  = (acc > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(acc);
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (finish) begin
            m_valid_next    = 1'b1;
            m_total_next    = sum_reg;
            m_overflow_next = dropped_reg;
            count_next      = '0;
            dropped_next    = 1'b0;
        end

        cell_ctrl.wr_en    = accept && !full;
        cell_ctrl.wr_idx   = count_reg[IDX_W-1:0];
        cell_ctrl.wr_cyl   = CYLINDER_BITS'(s_cylinder);
        cell_ctrl.mark_en  = take_pick;
        cell_ctrl.mark_idx = pick.idx;
        cell_ctrl.clr      = finish;
        cell_ctrl.head     = head_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            sweep_reg   <= '0;
            head_reg    <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sweep_reg   <= sweep_next;
            head_reg    <= head_next;
            sum_reg     <= sum_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_total_reg    <= m_total_next;
        m_overflow_reg <= m_overflow_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_total_movement = m_total_reg;
    assign m_overflow       = m_overflow_reg;

endmodule

// ===== rtl/sstf_chk.sv =====
module sstf_chk
    import sstf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last,
    input logic               m_valid,
    input logic               m_ready,
    input logic [TOTAL_W-1:0] m_total_movement,
    input logic               m_overflow,
    input logic               pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_movement) && $stable(m_overflow))
        else $error("pending result changed");

    // closing a batch starts scheduling, input stalls
    a_sched_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input taken right after last transaction");

    // a result only comes out of a scheduling pass
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without scheduling pass");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind sstf_seek_total_top sstf_chk u_sstf_chk (.*);
